/* hw/rtl/bbc_pkg.sv */
// bbc_pkg: shared types and constants of the bracket balance checker
// holds character codes, stack kind codes and the front-to-back operation struct
// no dependencies
package bbc_pkg;

  // default stack size, overridable on the top level
  localparam int unsigned STACK_DEPTH_DEF = 1024;

  // entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // bracket kind as kept on the stack
  localparam int unsigned KIND_W = 2;
  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_BRACE  = 2'd1;
  localparam kind_t KIND_SQUARE = 2'd2;
  localparam kind_t KIND_PAREN  = 2'd3;

  // character codes
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;

  // work for the back end
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_END
  } op_e;

  typedef struct packed {
    op_e   code;
    kind_t kind;
  } op_t;

endpackage

/* hw/rtl/bbc_if.sv */
// bbc_if: valid/ready channels of the bracket balance checker
// bbc_in_if carries one character or end marker, bbc_out_if one result
// no dependencies
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_text;

  modport source (output valid, symbol, end_of_text, input ready);
  modport sink   (input valid, symbol, end_of_text, output ready);
endinterface

interface bbc_out_if;
  logic valid;
  logic ready;
  logic balanced;
  logic depth_overflow;

  modport source (output valid, balanced, depth_overflow, input ready);
  modport sink   (input valid, balanced, depth_overflow, output ready);
endinterface

/* hw/rtl/bbc_ram.sv */
// bbc_ram: generic single write port, single read port ram with registered read
// no dependencies
module bbc_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bbc_front.sv */
// bbc_front: accepts items and classifies them into stack operations
// depends on bbc_pkg and bbc_if; ordinary characters are dropped here
module bbc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  bbc_in_if.sink         in_i,
  output logic           op_valid_o,
  output bbc_pkg::op_t   op_o,
  input  logic           op_ready_i
);

  logic         vld_q;
  bbc_pkg::op_t op_q;
  bbc_pkg::op_t op_d;
  logic         is_op;
  logic         accept;

  always_comb begin
    op_d  = '{code: bbc_pkg::OP_END, kind: bbc_pkg::KIND_BRACE};
    is_op = 1'b1;
    if (in_i.end_of_text) begin
      op_d.code = bbc_pkg::OP_END;
    end else begin
      unique case (in_i.symbol)
        bbc_pkg::CH_LBRACE:  op_d = '{code: bbc_pkg::OP_PUSH, kind: bbc_pkg::KIND_BRACE};
        bbc_pkg::CH_LSQUARE: op_d = '{code: bbc_pkg::OP_PUSH, kind: bbc_pkg::KIND_SQUARE};
        bbc_pkg::CH_LPAREN:  op_d = '{code: bbc_pkg::OP_PUSH, kind: bbc_pkg::KIND_PAREN};
        bbc_pkg::CH_RBRACE:  op_d = '{code: bbc_pkg::OP_POP, kind: bbc_pkg::KIND_BRACE};
        bbc_pkg::CH_RSQUARE: op_d = '{code: bbc_pkg::OP_POP, kind: bbc_pkg::KIND_SQUARE};
        bbc_pkg::CH_RPAREN:  op_d = '{code: bbc_pkg::OP_POP, kind: bbc_pkg::KIND_PAREN};
        default:             is_op = 1'b0;
      endcase
    end
  end

  assign in_i.ready = !vld_q || op_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= is_op;
    end else if (op_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_d;
    end
  end

  assign op_valid_o = vld_q;
  assign op_o       = op_q;

endmodule

/* hw/rtl/bbc_queue.sv */
// bbc_queue: short fifo of operations between front and back
// depends on bbc_pkg
module bbc_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  input  bbc_pkg::op_t push_op_i,
  output logic         push_ready_o,
  output logic         pop_valid_o,
  output bbc_pkg::op_t pop_op_o,
  input  logic         pop_ready_i
);

  localparam int unsigned Depth = bbc_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  bbc_pkg::op_t    slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_op_o     = slot_q[rd_ptr_q];

  assign do_push = push_valid_i && push_ready_o;
  assign do_pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

/* hw/rtl/bbc_back.sv */
// bbc_back: stack engine and result register; one operation per cycle, an
// end marker held while out_o stalls; depends on bbc_pkg, bbc_if, bbc_ram;
// top of stack in a register, the entry below it in the ram read register
module bbc_back #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         op_valid_i,
  input  bbc_pkg::op_t op_i,
  output logic         op_ready_o,
  bbc_out_if.source    out_o
);

  localparam int unsigned LvlW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  logic [LvlW-1:0]     level_q, level_d;
  logic                mis_q, mis_d;
  logic                ovf_q, ovf_d;
  bbc_pkg::kind_t      tos_q, tos_d;
  bbc_pkg::kind_t      below;
  logic                we;
  logic                full;
  logic                take;
  logic                slot_free;
  logic                res_load;
  logic                out_vld_q;
  logic                bal_q, ovf_out_q;
  logic [AddrW-1:0]    rd_addr;
  logic [LvlW-1:0]     rd_lvl;

  assign slot_free  = !out_vld_q || out_o.ready;
  assign op_ready_o = slot_free || (op_i.code != bbc_pkg::OP_END);
  assign take       = op_valid_i && op_ready_o;
  assign full       = level_q == LvlW'(STACK_DEPTH);

  always_comb begin
    level_d  = level_q;
    mis_d    = mis_q;
    ovf_d    = ovf_q;
    tos_d    = tos_q;
    we       = 1'b0;
    res_load = 1'b0;
    if (take) begin
      unique case (op_i.code)
        bbc_pkg::OP_END: begin
          level_d  = '0;
          mis_d    = 1'b0;
          ovf_d    = 1'b0;
          res_load = 1'b1;
        end
        bbc_pkg::OP_PUSH: begin
          if (!mis_q) begin
            if (full) begin
              mis_d = 1'b1;
              ovf_d = 1'b1;
            end else begin
              we      = 1'b1;
              level_d = level_q + 1'b1;
              tos_d   = op_i.kind;
            end
          end
        end
        bbc_pkg::OP_POP: begin
          if (!mis_q) begin
            if (level_q == '0 || tos_q != op_i.kind) begin
              mis_d = 1'b1;
            end else begin
              level_d = level_q - 1'b1;
              tos_d   = below;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // keep the entry under the new top in the read register
  assign rd_lvl  = level_d - LvlW'(2);
  assign rd_addr = rd_lvl[AddrW-1:0];

  bbc_ram #(
    .Width (bbc_pkg::KIND_W),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (level_q[AddrW-1:0]),
    .wdata_i (op_i.kind),
    .raddr_i (rd_addr),
    .rdata_o (below)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= '0;
      mis_q     <= 1'b0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      level_q <= level_d;
      mis_q   <= mis_d;
      ovf_q   <= ovf_d;
      if (res_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    if (res_load) begin
      bal_q     <= !mis_q && (level_q == '0);
      ovf_out_q <= ovf_q;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.balanced       = bal_q;
  assign out_o.depth_overflow = ovf_out_q;

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && op_i.code == bbc_pkg::OP_END |=> level_q == '0 && !mis_q && !ovf_q)
    else $error("string state not cleared after end marker");

  a_ovf_is_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> mis_q)
    else $error("overflow recorded without failure");

  a_push_tos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && op_i.code == bbc_pkg::OP_PUSH && !mis_q && !full
    |=> level_q == LvlW'($past(level_q) + 1'b1) && tos_q == $past(op_i.kind))
    else $error("push did not update level and top of stack");

endmodule

/* hw/rtl/bracket_balance_checker_core.sv */
// bracket_balance_checker_core: top level of the bracket balance checker
// depends on bbc_pkg, bbc_if, bbc_front, bbc_queue, bbc_back and bbc_ram
//
// usage
//   in_i carries one item per handshake: a character byte in symbol, or an end
//   marker with end_of_text set. opening braces, brackets and parentheses push
//   their kind, closing ones pop a matching kind; other characters are ignored.
//   out_o gives one item per end marker: balanced and depth_overflow for the
//   string just ended, after which the checker starts afresh.
// timing
//   one item per cycle on both channels when out_o is not stalled.
//   an end marker passes the front register and the queue before bbc_back
//   takes it and loads its result into the result register on out_o.
//   the rate is set by the stack engine in bbc_back: one push or pop a cycle,
//   with the top of stack in a register and the entry below it held in the
//   ram read register, updated from the next stack level every cycle.
// stalls
//   a stalled out_o keeps its result; the back end keeps running pushes and
//   pops, and holds only at the next end marker. the queue and the front
//   register then fill and in_i.ready drops.
// reset
//   rst_ni clears level, failure flags and all valids at once. the stack ram is
//   not cleared: only entries written in the current string are used.
module bracket_balance_checker_core #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbc_in_if.sink    in_i,
  bbc_out_if.source out_o
);

  // front to queue
  logic         fr_valid;
  logic         fr_ready;
  bbc_pkg::op_t fr_op;

  // queue to back
  logic         bk_valid;
  logic         bk_ready;
  bbc_pkg::op_t bk_op;

  // classification; ordinary characters never leave the front
  bbc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .op_valid_o (fr_valid),
    .op_o       (fr_op),
    .op_ready_i (fr_ready)
  );

  // decouples the front from a back end held by an output stall
  bbc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_op_i    (fr_op),
    .push_ready_o (fr_ready),
    .pop_valid_o  (bk_valid),
    .pop_op_o     (bk_op),
    .pop_ready_i  (bk_ready)
  );

  // stack engine and result register
  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (bk_valid),
    .op_i       (bk_op),
    .op_ready_o (bk_ready),
    .out_o      (out_o)
  );

endmodule

/* test/tb_bracket_balance_checker_core.sv */
// tb_bracket_balance_checker_core: self-checking testbench of the bracket balance checker
// drives strings of characters and end markers, predicts each verdict and compares it
// depends on bbc_pkg, bbc_if and bracket_balance_checker_core
`timescale 1ns / 100ps

module tb_bracket_balance_checker_core;

  localparam int unsigned DEPTH = bbc_pkg::STACK_DEPTH_DEF;
  // longest correct quiet stretch is the receiver hold-off, so this is ample
  localparam int WATCHDOG_LIMIT = 1000;
  // allow a margin at the end of the run, once every verdict has come back
  localparam int DRAIN_CYCLES = 10;
  // minimum items sent by the random phase; the stack limit test alone needs a full stack
  localparam int RANDOM_ITEMS = 150;
  localparam int HOLD_LEN = 150;

  typedef struct packed {
    logic balanced;
    logic depth_overflow;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bbc_in_if  in_if ();
  bbc_out_if out_if ();

  bracket_balance_checker_core #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted state of the nesting tracker
  bbc_pkg::kind_t nest_stack [DEPTH];
  int unsigned    nest_level = 0;
  bit             failed     = 1'b0;
  bit             overflowed = 1'b0;
  verdict_t       verdicts [$];

  int error_count     = 0;
  int items_sent      = 0;
  int counted_items   = 0;
  int verdicts_seen   = 0;
  int balanced_seen   = 0;
  int overflows_seen  = 0;
  int quiet_cycles    = 0;
  int hold_cycles     = 0;
  int stall_left      = 0;
  bit hold_req        = 1'b0;
  bit hold_ack        = 1'b0;
  bit tx_idle_en      = 1'b1;
  bit rx_idle_en      = 1'b1;

  task automatic report_fault(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [7:0] open_char(input bbc_pkg::kind_t k);
    case (k)
      bbc_pkg::KIND_BRACE:  return bbc_pkg::CH_LBRACE;
      bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_LSQUARE;
      default:              return bbc_pkg::CH_LPAREN;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input bbc_pkg::kind_t k);
    case (k)
      bbc_pkg::KIND_BRACE:  return bbc_pkg::CH_RBRACE;
      bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_RSQUARE;
      default:              return bbc_pkg::CH_RPAREN;
    endcase
  endfunction

  function automatic bbc_pkg::kind_t random_kind();
    return bbc_pkg::kind_t'($urandom_range(bbc_pkg::KIND_BRACE, bbc_pkg::KIND_PAREN));
  endfunction

  function automatic void push_open(input bbc_pkg::kind_t k);
    if (nest_level >= DEPTH) begin
      // full stack: the push is dropped and the string fails
      failed     = 1'b1;
      overflowed = 1'b1;
    end else begin
      nest_stack[nest_level] = k;
      nest_level++;
    end
  endfunction

  function automatic void pop_close(input bbc_pkg::kind_t k);
    if (nest_level == 0 || nest_stack[nest_level-1] != k) failed = 1'b1;
    else nest_level--;
  endfunction

  // advance the predicted tracker by one accepted item
  function automatic void track_brackets(input logic [7:0] sym, input logic eot);
    verdict_t v;
    if (eot) begin
      v.balanced       = !failed && nest_level == 0;
      v.depth_overflow = overflowed;
      verdicts.push_back(v);
      nest_level = 0;
      failed     = 1'b0;
      overflowed = 1'b0;
    end else if (!failed) begin
      case (sym)
        bbc_pkg::CH_LBRACE:  push_open(bbc_pkg::KIND_BRACE);
        bbc_pkg::CH_LSQUARE: push_open(bbc_pkg::KIND_SQUARE);
        bbc_pkg::CH_LPAREN:  push_open(bbc_pkg::KIND_PAREN);
        bbc_pkg::CH_RBRACE:  pop_close(bbc_pkg::KIND_BRACE);
        bbc_pkg::CH_RSQUARE: pop_close(bbc_pkg::KIND_SQUARE);
        bbc_pkg::CH_RPAREN:  pop_close(bbc_pkg::KIND_PAREN);
        default: ;
      endcase
    end
  endfunction

  function automatic bit is_bracket(input logic [7:0] sym);
    return sym inside {bbc_pkg::CH_LBRACE, bbc_pkg::CH_LSQUARE, bbc_pkg::CH_LPAREN,
                       bbc_pkg::CH_RBRACE, bbc_pkg::CH_RSQUARE, bbc_pkg::CH_RPAREN};
  endfunction

  // offer one item, optionally after a gap, and return at the edge that takes it
  task automatic send_item(input logic [7:0] sym, input logic eot);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.symbol      <= sym;
    in_if.end_of_text <= eot;
    do @(posedge clk_i); while (!in_if.ready);
    track_brackets(sym, eot);
    items_sent++;
    if (eot || is_bracket(sym)) counted_items++;
  endtask

  // sender pause: nothing offered until every predicted verdict has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one string with random content: mostly well nested, some corrupted, some noise
  task automatic send_random_string();
    bbc_pkg::kind_t open_kinds [$];
    bbc_pkg::kind_t k;
    int             len;
    int             shape;
    bit             corrupt;
    shape   = $urandom_range(0, 99);
    len     = $urandom_range(0, 24);
    corrupt = shape < 35;
    if (shape < 15) begin
      repeat (len) begin
        k = random_kind();
        if ($urandom_range(0, 1)) begin
          send_item($urandom_range(0, 1) ? open_char(k) : close_char(k), 1'b0);
        end else begin
          send_item(8'($urandom_range(0, 255)), 1'b0);
        end
      end
    end else begin
      repeat (len) begin
        shape = $urandom_range(0, 99);
        if (open_kinds.size() > 0 && shape < 40) begin
          k = open_kinds.pop_back();
          if (corrupt && $urandom_range(0, 9) == 0) k = random_kind();
          send_item(close_char(k), 1'b0);
        end else if (shape < 80 && open_kinds.size() < 16) begin
          k = random_kind();
          open_kinds.push_back(k);
          send_item(open_char(k), 1'b0);
        end else begin
          send_item(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      if (corrupt && $urandom_range(0, 1)) begin
        // leave the string unclosed or close once too often
        if ($urandom_range(0, 1)) send_item(close_char(random_kind()), 1'b0);
      end else begin
        while (open_kinds.size() > 0) send_item(close_char(open_kinds.pop_back()), 1'b0);
      end
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_directed();
    // empty string
    send_item(8'h00, 1'b1);
    // every kind pushed and popped, properly nested
    send_item(bbc_pkg::CH_LBRACE, 1'b0);
    send_item(bbc_pkg::CH_LSQUARE, 1'b0);
    send_item(bbc_pkg::CH_LPAREN, 1'b0);
    send_item(bbc_pkg::CH_RPAREN, 1'b0);
    send_item(bbc_pkg::CH_RSQUARE, 1'b0);
    send_item(bbc_pkg::CH_RBRACE, 1'b0);
    send_item(8'hFF, 1'b1);
    // close on an empty stack
    send_item(bbc_pkg::CH_RPAREN, 1'b0);
    send_item(8'h00, 1'b1);
    // close of the wrong kind
    send_item(bbc_pkg::CH_LPAREN, 1'b0);
    send_item(bbc_pkg::CH_RSQUARE, 1'b0);
    send_item(8'h00, 1'b1);
    // failure latched, later brackets ignored
    send_item(bbc_pkg::CH_RBRACE, 1'b0);
    send_item(bbc_pkg::CH_LBRACE, 1'b0);
    send_item(bbc_pkg::CH_RBRACE, 1'b0);
    send_item(8'h00, 1'b1);
    // zero byte, plain letter and top byte are ignored; end marker ignores its symbol
    send_item(8'h00, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(bbc_pkg::CH_LPAREN, 1'b1);
    // left open
    send_item(bbc_pkg::CH_LSQUARE, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_stack_limits();
    bbc_pkg::kind_t kinds [$];
    bbc_pkg::kind_t k;
    // fill to exactly full, step back once and refill
    repeat (DEPTH) begin
      k = random_kind();
      kinds.push_back(k);
      send_item(open_char(k), 1'b0);
    end
    send_item(close_char(kinds.pop_back()), 1'b0);
    k = random_kind();
    kinds.push_back(k);
    send_item(open_char(k), 1'b0);
    // one push past full: overflow, and the matching close afterwards is ignored
    send_item(open_char(random_kind()), 1'b0);
    send_item(close_char(kinds.pop_back()), 1'b0);
    send_item(8'h00, 1'b1);
    // state must be clean again
    send_item(bbc_pkg::CH_LPAREN, 1'b0);
    send_item(bbc_pkg::CH_RPAREN, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // receiver holds off while short strings keep coming, so the input stalls
  task automatic test_backpressure();
    hold_req   = !hold_req;
    tx_idle_en = 1'b0;
    repeat (20) begin
      send_item(bbc_pkg::CH_LPAREN, 1'b0);
      send_item(bbc_pkg::CH_RPAREN, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_strings();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) send_random_string();
  endtask

  // back to back on both sides
  task automatic test_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (6) send_random_string();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // receiver: random stalls, plus a long hold-off when a test asks for one
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    = hold_req;
      hold_cycles = HOLD_LEN;
    end
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = rx_idle_en ? pick_gap() : 0;
      out_if.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // verdict checker: each result against the oldest prediction
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (verdicts.size() == 0) begin
        report_fault("verdict arrived with none predicted");
      end else begin
        want = verdicts.pop_front();
        if (out_if.balanced !== want.balanced)
          report_fault($sformatf("verdict %0d balanced: expected %0b, got %b",
                                 verdicts_seen, want.balanced, out_if.balanced));
        if (out_if.depth_overflow !== want.depth_overflow)
          report_fault($sformatf("verdict %0d depth_overflow: expected %0b, got %b",
                                 verdicts_seen, want.depth_overflow, out_if.depth_overflow));
        verdicts_seen++;
        if (want.balanced) balanced_seen++;
        if (want.depth_overflow) overflows_seen++;
      end
    end
  end

  // watchdog on cycles in which neither channel moves an item
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d verdicts outstanding",
                 quiet_cycles, verdicts.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.symbol      <= 8'h00;
    in_if.end_of_text <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    wait_drained();
    test_stack_limits();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random_strings();
    test_no_idle();

    in_if.valid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d items in total, %0d of them brackets or end markers",
             items_sent, counted_items);
    $display("checked %0d verdicts: %0d balanced, %0d with depth overflow, %0d faults",
             verdicts_seen, balanced_seen, overflows_seen, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_if.sv
hw/rtl/bbc_ram.sv
hw/rtl/bbc_front.sv
hw/rtl/bbc_queue.sv
hw/rtl/bbc_back.sv
hw/rtl/bracket_balance_checker_core.sv
test/tb_bracket_balance_checker_core.sv
